@@ sv/tsd_pkg.sv @@
`timescale 1ns / 1ps
package tsd_pkg;

    localparam logic [2:0] ST_PIXEL      = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
    localparam logic [2:0] ST_MISMATCH   = 3'd2;
    localparam logic [2:0] ST_BAD_TYPE   = 3'd3;
    localparam logic [2:0] ST_BAD_DEPTH  = 3'd4;
    localparam logic [2:0] ST_BAD_MAPDEP = 3'd5;
    localparam logic [2:0] ST_MAP_BIG    = 3'd6;
    localparam logic [2:0] ST_REFUSED    = 3'd7;

    localparam int HDR_LEN = 18;

    // Header image type codes.
    localparam logic [7:0] TYPE_MAP      = 8'd1;
    localparam logic [7:0] TYPE_TRUE     = 8'd2;
    localparam logic [7:0] TYPE_GREY     = 8'd3;
    localparam logic [7:0] TYPE_RLE_MAP  = 8'd9;
    localparam logic [7:0] TYPE_RLE_TRUE = 8'd10;
    localparam logic [7:0] TYPE_RLE_GREY = 8'd11;

    function automatic logic depth_ok(input logic [7:0] d);
        return d == 8'd8 || d == 8'd15 || d == 8'd16 || d == 8'd24 || d == 8'd32;
    endfunction

    function automatic logic [1:0] last_phase(input logic [7:0] d);
        logic [1:0] n;
        n = 2'd0;
        if (d == 8'd15 || d == 8'd16) n = 2'd1;
        else if (d == 8'd24) n = 2'd2;
        else if (d == 8'd32) n = 2'd3;
        return n;
    endfunction

    // Returns {alpha, blue, green, red}; the word holds the first byte lowest.
    function automatic logic [31:0] px_decode(input logic [7:0] d, input logic [31:0] w);
        logic [7:0] r, g, b, a;
        r = w[7:0];
        g = w[7:0];
        b = w[7:0];
        a = 8'hFF;
        if (d == 8'd15 || d == 8'd16) begin
            r = {w[14:10], 3'b000};
            g = {w[9:5], 3'b000};
            b = {w[4:0], 3'b000};
            a = (d == 8'd15 || w[15]) ? 8'hFF : 8'h00;
        end else if (d == 8'd24) begin
            b = w[7:0];
            g = w[15:8];
            r = w[23:16];
        end else if (d == 8'd32) begin
            b = w[7:0];
            g = w[15:8];
            r = w[23:16];
            a = w[31:24];
        end
        return {a, b, g, r};
    endfunction

endpackage

@@ sv/tga_stream_decoder_top.sv @@
`timescale 1ns / 1ps
// Streaming TGA decoder. The s_ channel carries one request per file byte
// (s_cmd 0, s_first_byte marks byte 0 of a new file) or a step request
// (s_cmd 1) that releases one pending pixel of a replicated RLE run.
// The m_ channel returns at most one result per request: a pixel with its
// destination row and column and RGBA color, or a status code for a
// header error or for a byte refused while a run is pending.
// The cfg_ channel writes match_width (address 0) or match_height
// (address 1); it is always ready. The user must write it only while
// idle; the block does not enforce this. The parser updates its state
// and issues the palette read at acceptance, then the palette data is
// merged into the output register. One request is taken every cycle
// while s_ready is high, as the parser step is combinational and the
// palette is read once. A stalled m_ channel holds its result; the
// block keeps accepting until its one internal stage is also full, then
// drops s_ready. Reset (aresetn low, synchronous) returns the parser to
// the header phase and empties the pipeline. The palette is not cleared
// and needs no clearing pass.
module tga_stream_decoder_top #(
    parameter int MAP_DEPTH = 16384,
    parameter int MAX_DIM   = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_byte_value,
    input  logic        s_first_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [12:0] m_row,
    output logic [12:0] m_column,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,
    input  logic [13:0] cfg_data
);
    import tsd_pkg::*;

    localparam int AW = $clog2(MAP_DEPTH);
    localparam int DW = $clog2(MAX_DIM) + 1;
    localparam logic [16:0] MAP_LIMIT = 17'(MAP_DEPTH);
    localparam logic [17:0] MAP_LIMIT18 = 18'(MAP_DEPTH);
    localparam logic [15:0] DIM_LIMIT = 16'(MAX_DIM);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_IDSKIP = 3'd1;
    localparam logic [2:0] PH_CMAP   = 3'd2;
    localparam logic [2:0] PH_PACKET = 3'd3;
    localparam logic [2:0] PH_PIXEL  = 3'd4;
    localparam logic [2:0] PH_REPL   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;
    localparam logic [2:0] PH_ERROR  = 3'd7;

    // Configuration
    logic [13:0] match_w_reg, match_h_reg;

    // Parser state
    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  hcount_reg, hcount_next;
    logic [7:0]  h_id_reg, h_id_next, h_cmt_reg, h_cmt_next, h_type_reg, h_type_next;
    logic [15:0] h_cmfirst_reg, h_cmfirst_next, h_cmlen_reg, h_cmlen_next;
    logic [7:0]  h_cmdep_reg, h_cmdep_next;
    logic [15:0] h_w_reg, h_w_next, h_h_reg, h_h_next;
    logic [7:0]  h_dep_reg, h_dep_next, h_desc_reg, h_desc_next;
    logic [7:0]  skip_reg, skip_next;
    logic [AW:0] twi_reg, twi_next;
    logic [1:0]  bphase_reg, bphase_next;
    logic [23:0] partial_reg, partial_next;
    logic [7:0]  run_reg, run_next;
    logic        repl_reg, repl_next;
    logic [31:0] held_reg, held_next;
    logic [DW-1:0] col_reg, col_next, rows_reg, rows_next;
    logic [DW-1:0] trow_reg, trow_next, base_reg, base_next;

    // Palette
    logic [31:0]   pal_mem [MAP_DEPTH];
    logic [31:0]   pal_rdata_reg;
    logic          pal_we, pal_re;
    logic [AW-1:0] pal_waddr, pal_raddr;
    logic [31:0]   pal_wdata;

    // Stage 1 and output stage
    logic        s1_valid_reg, s1_map_reg, s1_zero_reg, s1_last_reg;
    logic [2:0]  s1_status_reg;
    logic [12:0] s1_row_reg, s1_col_reg;
    logic [31:0] s1_rgba_reg;
    logic        s1_adv, accept;
    logic        m_valid_reg, m_last_reg;
    logic [2:0]  m_status_reg;
    logic [12:0] m_row_reg, m_col_reg;
    logic [31:0] m_rgba_reg;

    // Result of this request
    logic        res_valid, res_map, res_zero, res_last;
    logic [2:0]  res_status;
    logic [12:0] res_row, res_col;
    logic [31:0] res_rgba;

    assign s1_adv    = !m_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || s1_adv;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        logic        fb, mapped, rle, emit, emit_map, done, from_step;
        logic [31:0] word, rgba, emit_val;
        logic [15:0] idx;
        logic [17:0] map_sum;
        logic [DW-1:0] w, h, step_rows, col_inc, rows_inc;
        logic [1:0]  il;
        logic [2:0]  code;

        fb = !s_cmd && s_first_byte;
        phase_next     = fb ? PH_HEADER : phase_reg;
        hcount_next    = fb ? 5'd0 : hcount_reg;
        h_id_next      = fb ? 8'd0 : h_id_reg;
        h_cmt_next     = fb ? 8'd0 : h_cmt_reg;
        h_type_next    = fb ? 8'd0 : h_type_reg;
        h_cmfirst_next = fb ? 16'd0 : h_cmfirst_reg;
        h_cmlen_next   = fb ? 16'd0 : h_cmlen_reg;
        h_cmdep_next   = fb ? 8'd0 : h_cmdep_reg;
        h_w_next       = fb ? 16'd0 : h_w_reg;
        h_h_next       = fb ? 16'd0 : h_h_reg;
        h_dep_next     = fb ? 8'd0 : h_dep_reg;
        h_desc_next    = fb ? 8'd0 : h_desc_reg;
        skip_next      = fb ? 8'd0 : skip_reg;
        twi_next       = fb ? '0 : twi_reg;
        bphase_next    = fb ? 2'd0 : bphase_reg;
        partial_next   = fb ? 24'd0 : partial_reg;
        run_next       = fb ? 8'd0 : run_reg;
        repl_next      = fb ? 1'b0 : repl_reg;
        held_next      = fb ? 32'd0 : held_reg;
        col_next       = fb ? '0 : col_reg;
        rows_next      = fb ? '0 : rows_reg;
        trow_next      = fb ? '0 : trow_reg;
        base_next      = fb ? '0 : base_reg;

        res_valid  = 1'b0;
        res_status = ST_PIXEL;
        res_map    = 1'b0;
        res_zero   = 1'b0;
        res_last   = 1'b0;
        res_row    = 13'd0;
        res_col    = 13'd0;
        res_rgba   = 32'd0;
        pal_we     = 1'b0;
        pal_waddr  = twi_next[AW-1:0];
        pal_re     = 1'b0;
        pal_raddr  = '0;
        emit       = 1'b0;
        emit_map   = 1'b0;
        emit_val   = 32'd0;
        from_step  = 1'b0;
        code       = ST_PIXEL;

        mapped = (h_type_next == TYPE_MAP || h_type_next == TYPE_RLE_MAP) && h_cmt_next == 8'd1;
        rle    = h_type_next == TYPE_RLE_MAP || h_type_next == TYPE_RLE_TRUE
                 || h_type_next == TYPE_RLE_GREY;
        word   = {8'd0, partial_next} | ({24'd0, s_byte_value} << {bphase_next, 3'b000});
        pal_wdata = px_decode(h_cmdep_next, word);
        rgba   = px_decode(h_dep_next, word);
        idx    = (h_dep_next == 8'd15 || h_dep_next == 8'd16) ? word[15:0]
               : (h_dep_next == 8'd8) ? {8'd0, word[7:0]} : 16'd0;
        map_sum = {2'b00, h_cmfirst_next} + {2'b00, h_cmlen_next} + 18'd1;

        if (s_cmd) begin
            if (phase_reg == PH_REPL) begin
                emit      = 1'b1;
                emit_map  = mapped;
                emit_val  = held_reg;
                from_step = 1'b1;
            end
        end else begin
            case (phase_next)
                PH_HEADER: begin
                    case (hcount_next)
                        5'd0:  h_id_next = s_byte_value;
                        5'd1:  h_cmt_next = s_byte_value;
                        5'd2:  h_type_next = s_byte_value;
                        5'd3:  h_cmfirst_next[7:0] = s_byte_value;
                        5'd4:  h_cmfirst_next[15:8] = s_byte_value;
                        5'd5:  h_cmlen_next[7:0] = s_byte_value;
                        5'd6:  h_cmlen_next[15:8] = s_byte_value;
                        5'd7:  h_cmdep_next = s_byte_value;
                        5'd12: h_w_next[7:0] = s_byte_value;
                        5'd13: h_w_next[15:8] = s_byte_value;
                        5'd14: h_h_next[7:0] = s_byte_value;
                        5'd15: h_h_next[15:8] = s_byte_value;
                        5'd16: h_dep_next = s_byte_value;
                        5'd17: h_desc_next = s_byte_value;
                        default: ;
                    endcase
                    hcount_next = hcount_next + 5'd1;
                    if (hcount_next == 5'(HDR_LEN)) begin
                        if (h_w_next > DIM_LIMIT || h_h_next > DIM_LIMIT)
                            code = ST_TOO_LARGE;
                        else if ((match_w_reg != 14'd0 && h_w_next != {2'b00, match_w_reg})
                                 || (match_h_reg != 14'd0 && h_h_next != {2'b00, match_h_reg}))
                            code = ST_MISMATCH;
                        else if (!(h_type_next == TYPE_MAP || h_type_next == TYPE_TRUE
                                   || h_type_next == TYPE_GREY || rle))
                            code = ST_BAD_TYPE;
                        else if (!depth_ok(h_dep_next))
                            code = ST_BAD_DEPTH;
                        else if (mapped && !depth_ok(h_cmdep_next))
                            code = ST_BAD_MAPDEP;
                        else if (mapped && map_sum >= MAP_LIMIT18)
                            code = ST_MAP_BIG;
                        if (code != ST_PIXEL) begin
                            phase_next = PH_ERROR;
                            res_valid  = 1'b1;
                            res_status = code;
                        end else begin
                            skip_next  = h_id_next;
                            phase_next = (h_id_next != 8'd0) ? PH_IDSKIP : PH_CMAP;
                        end
                    end
                end
                PH_IDSKIP: begin
                    skip_next = skip_next - 8'd1;
                    if (skip_next == 8'd0) phase_next = PH_CMAP;
                end
                PH_CMAP: begin
                    if (bphase_next < last_phase(h_cmdep_next)) begin
                        partial_next = word[23:0];
                        bphase_next  = bphase_next + 2'd1;
                    end else begin
                        pal_we       = 17'(twi_next) < MAP_LIMIT;
                        twi_next     = twi_next + 1'b1;
                        bphase_next  = 2'd0;
                        partial_next = 24'd0;
                        if (17'(twi_next) >= {1'b0, h_cmlen_next})
                            phase_next = PH_PACKET;
                        else
                            phase_next = PH_CMAP;
                    end
                end
                PH_PACKET: begin
                    run_next     = {1'b0, s_byte_value[6:0]} + 8'd1;
                    repl_next    = s_byte_value[7];
                    bphase_next  = 2'd0;
                    partial_next = 24'd0;
                    phase_next   = PH_PIXEL;
                end
                PH_PIXEL: begin
                    if (bphase_next < last_phase(h_dep_next)) begin
                        partial_next = word[23:0];
                        bphase_next  = bphase_next + 2'd1;
                    end else begin
                        bphase_next  = 2'd0;
                        partial_next = 24'd0;
                        emit     = 1'b1;
                        emit_map = mapped;
                        emit_val = mapped ? {16'd0, idx} : rgba;
                    end
                end
                PH_REPL: begin
                    res_valid  = 1'b1;
                    res_status = ST_REFUSED;
                end
                default: ;
            endcase
        end

        // Leaving the header or the map: either more map, or the body begins.
        if (!s_cmd && (phase_next == PH_CMAP) && (phase_reg != PH_CMAP || fb)) begin
            if (mapped && h_cmlen_next != 16'd0) begin
                twi_next     = '0;
                bphase_next  = 2'd0;
                partial_next = 24'd0;
            end else begin
                phase_next = PH_PACKET;
            end
        end
        if (!s_cmd && phase_next == PH_PACKET && (phase_reg == PH_HEADER || fb
                || phase_reg == PH_IDSKIP || phase_reg == PH_CMAP)) begin
            col_next = '0; rows_next = '0; trow_next = '0; base_next = '0;
            run_next = 8'd0; repl_next = 1'b0; bphase_next = 2'd0; partial_next = 24'd0;
            if (h_w_next == 16'd0 || h_h_next == 16'd0) phase_next = PH_DONE;
            else phase_next = rle ? PH_PACKET : PH_PIXEL;
        end

        w  = h_w_next[DW-1:0];
        h  = h_h_next[DW-1:0];
        il = h_desc_next[7:6];
        step_rows = (il == 2'd2) ? DW'(4) : (il == 2'd1) ? DW'(2) : DW'(1);
        col_inc   = col_next + 1'b1;
        rows_inc  = rows_next + 1'b1;
        done      = 1'b0;
        if (emit) begin
            res_valid  = 1'b1;
            res_status = ST_PIXEL;
            res_row    = h_desc_next[5] ? trow_next[12:0] : 13'(h - 1'b1 - trow_next);
            res_col    = col_next[12:0];
            res_last   = rows_inc == h && col_inc == w;
            res_map    = emit_map;
            res_zero   = emit_map && ({1'b0, emit_val[15:0]} >= MAP_LIMIT);
            res_rgba   = emit_val;
            pal_re     = emit_map;
            pal_raddr  = emit_val[AW-1:0];
            col_next   = col_inc;
            if (col_inc >= w) begin
                col_next  = '0;
                rows_next = rows_inc;
                trow_next = trow_next + step_rows;
                if (trow_next >= h) begin
                    base_next = base_next + 1'b1;
                    trow_next = base_next;
                end
            end
            done = rows_next >= h;
            if (from_step) begin
                if (run_next != 8'd0) run_next = run_next - 8'd1;
                if (done) phase_next = PH_DONE;
                else if (run_next == 8'd0) phase_next = PH_PACKET;
            end else begin
                if (rle && run_next != 8'd0) run_next = run_next - 8'd1;
                if (done) begin
                    phase_next = PH_DONE;
                end else if (rle) begin
                    if (repl_next && run_next != 8'd0) begin
                        held_next  = emit_val;
                        phase_next = PH_REPL;
                    end else if (run_next == 8'd0) begin
                        phase_next = PH_PACKET;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_w_reg <= 14'd0;
            match_h_reg <= 14'd0;
        end else if (cfg_valid) begin
            if (cfg_addr) match_h_reg <= cfg_data;
            else match_w_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            hcount_reg    <= 5'd0;
            h_id_reg      <= 8'd0;
            h_cmt_reg     <= 8'd0;
            h_type_reg    <= 8'd0;
            h_cmfirst_reg <= 16'd0;
            h_cmlen_reg   <= 16'd0;
            h_cmdep_reg   <= 8'd0;
            h_w_reg       <= 16'd0;
            h_h_reg       <= 16'd0;
            h_dep_reg     <= 8'd0;
            h_desc_reg    <= 8'd0;
            skip_reg      <= 8'd0;
            twi_reg       <= '0;
            bphase_reg    <= 2'd0;
            partial_reg   <= 24'd0;
            run_reg       <= 8'd0;
            repl_reg      <= 1'b0;
            held_reg      <= 32'd0;
            col_reg       <= '0;
            rows_reg      <= '0;
            trow_reg      <= '0;
            base_reg      <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            hcount_reg    <= hcount_next;
            h_id_reg      <= h_id_next;
            h_cmt_reg     <= h_cmt_next;
            h_type_reg    <= h_type_next;
            h_cmfirst_reg <= h_cmfirst_next;
            h_cmlen_reg   <= h_cmlen_next;
            h_cmdep_reg   <= h_cmdep_next;
            h_w_reg       <= h_w_next;
            h_h_reg       <= h_h_next;
            h_dep_reg     <= h_dep_next;
            h_desc_reg    <= h_desc_next;
            skip_reg      <= skip_next;
            twi_reg       <= twi_next;
            bphase_reg    <= bphase_next;
            partial_reg   <= partial_next;
            run_reg       <= run_next;
            repl_reg      <= repl_next;
            held_reg      <= held_next;
            col_reg       <= col_next;
            rows_reg      <= rows_next;
            trow_reg      <= trow_next;
            base_reg      <= base_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && pal_we) pal_mem[pal_waddr] <= pal_wdata;
        if (accept && pal_re) pal_rdata_reg <= pal_mem[pal_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= res_valid;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_status_reg <= res_status;
            s1_row_reg    <= res_row;
            s1_col_reg    <= res_col;
            s1_rgba_reg   <= res_rgba;
            s1_last_reg   <= res_last;
            s1_map_reg    <= res_map;
            s1_zero_reg   <= res_zero;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_status_reg <= s1_status_reg;
            m_row_reg    <= s1_row_reg;
            m_col_reg    <= s1_col_reg;
            m_last_reg   <= s1_last_reg;
            m_rgba_reg   <= !s1_map_reg ? s1_rgba_reg
                          : s1_zero_reg ? 32'd0 : pal_rdata_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_row    = m_row_reg;
    assign m_column = m_col_reg;
    assign m_red    = m_rgba_reg[7:0];
    assign m_green  = m_rgba_reg[15:8];
    assign m_blue   = m_rgba_reg[23:16];
    assign m_alpha  = m_rgba_reg[31:24];
    assign m_last   = m_last_reg;

`ifndef SYNTHESIS
    a_ready_low_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && m_valid_reg))
        else $error("input stalled with a free stage");
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_PIXEL) |-> (m_row == 13'd0 && m_column == 13'd0
            && m_last == 1'b0 && m_alpha == 8'd0))
        else $error("status result carries pixel data");
    a_reset_header: assert property (@(posedge aclk)
        $past(!aresetn) |-> (phase_reg == PH_HEADER && !m_valid_reg && !s1_valid_reg))
        else $error("parser not cleared by reset");
    a_repl_run: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_REPL |-> run_reg != 8'd0)
        else $error("replication pending with an empty run");
`endif

endmodule
